// ===== rtl/core/qmsu_pkg.sv =====
`timescale 1ns / 1ps

package qmsu_pkg;

  // Q16 values of exp(-f) for f = 0, 1/16, ..., 1.
  localparam logic [16:0] EXP_FRAC_Q16 [17] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947,
    17'd45043, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954,
    17'd30957, 17'd29081, 17'd27319, 17'd25664, 17'd24109
  };

  // Q16 values of exp(-i) for i = 0..11; the upper entries are never used.
  localparam logic [16:0] EXP_INT_Q16 [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
    17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1,
    17'd0, 17'd0, 17'd0, 17'd0
  };

  // A product delta*beta at or above 12.0 in Q16.16 always rejects.
  localparam logic [63:0] P_LIMIT = 64'h0000_0000_000C_0000;

  typedef enum logic [1:0] {
    KIND_COUPLING = 2'd0,
    KIND_SPIN     = 2'd1,
    KIND_ENERGY   = 2'd2,
    KIND_CONSIDER = 2'd3
  } kind_t;

endpackage

// ===== rtl/core/qmsu_ram.sv =====
`timescale 1ns / 1ps

module qmsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/qmsu_accept.sv =====
`timescale 1ns / 1ps

// Four-stage Metropolis test: product, table interpolation, scale, compare.
module qmsu_accept #(
  parameter int ENERGY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ENERGY_BITS-1:0] delta,
  input  logic [31:0]                   beta,
  input  logic [15:0]                   u,
  output logic                          done,
  output logic                          take
);

  logic [3:0]  vld_r;
  logic [63:0] d64;
  logic        imm1_r, rej1_r, imm2_r, rej2_r, imm3_r, rej3_r;
  logic [63:0] p1_r;
  logic [15:0] u1_r, u2_r, u3_r;
  logic [16:0] fk, fk1, fk2_r;
  logic [28:0] prod2_r;
  logic [3:0]  i2_r;
  logic [16:0] v3;
  logic [33:0] eprod3_r;
  logic [34:0] e_sum;
  logic        take_r;

  assign d64 = {{(64-ENERGY_BITS){delta[ENERGY_BITS-1]}}, delta};
  assign fk  = qmsu_pkg::EXP_FRAC_Q16[{1'b0, p1_r[15:12]}];
  assign fk1 = qmsu_pkg::EXP_FRAC_Q16[{1'b0, p1_r[15:12]} + 5'd1];
  assign v3  = fk2_r - 17'((30'(prod2_r) + 30'd2048) >> 12);
  assign e_sum = 35'(eprod3_r) + 35'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    imm1_r  <= d64[63] || (d64 == 64'd0) || (beta == 32'd0);
    rej1_r  <= |d64[63:32];
    p1_r    <= 64'(d64[31:0]) * 64'(beta);
    u1_r    <= u;
    imm2_r  <= imm1_r;
    rej2_r  <= rej1_r || (p1_r >= qmsu_pkg::P_LIMIT);
    fk2_r   <= fk;
    prod2_r <= 29'(fk - fk1) * 29'(p1_r[11:0]);
    i2_r    <= p1_r[19:16];
    u2_r    <= u1_r;
    imm3_r  <= imm2_r;
    rej3_r  <= rej2_r;
    eprod3_r <= 34'(qmsu_pkg::EXP_INT_Q16[i2_r]) * 34'(v3);
    u3_r    <= u2_r;
    take_r  <= imm3_r || (!rej3_r && (19'(u3_r) < e_sum[34:16]));
  end

  assign done = vld_r[3];
  assign take = take_r;

endmodule

// ===== rtl/core/qubo_metropolis_spin_update_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    kind, indexes, loads, beta, random
// out_      output     out_valid / out_ready  accepted, spin_now, energy_now, delta_now
// cfg_      input      cfg_we (no wait)       spin_count
//
// A load passes through S_READ, S_LOOK and S_DONE; a consider on a valid row also
// waits in S_EVAL for the acceptance test, and an accepted flip then runs S_OWN and
// a sweep over n spins, n being spin_count capped at MAX_SPINS: the sweep reads one
// spin and one coupling per cycle and writes each updated delta in the cycle after.
// Reset is synchronous and clears control, energy, spin_count (to 64) and the
// per-entry valid bits of the spin memory; the coupling memory is not cleared.
// A result waits in the output register while the next item is taken in; a
// finished item whose result cannot yet be loaded holds the block until it can.

module qubo_metropolis_spin_update_unit #(
  parameter int MAX_SPINS     = 64,
  parameter int COUPLING_BITS = 16,
  parameter int ENERGY_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic signed [15:0] in_coupling_value,
  input  logic               in_spin_value,
  input  logic signed [31:0] in_delta_value,
  input  logic signed [31:0] in_energy_value,
  input  logic [31:0]        in_inverse_temp,
  input  logic [15:0]        in_random_fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic               out_spin_now,
  output logic signed [31:0] out_energy_now,
  output logic signed [31:0] out_delta_now,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  localparam int SAW   = $clog2(MAX_SPINS);
  localparam int CAW   = $clog2(MAX_SPINS * MAX_SPINS);
  localparam int CNT_W = $clog2(MAX_SPINS + 1);
  localparam int EB    = ENERGY_BITS;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (EB - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  // Each state owns one duty; S_EVAL waits for the test, S_SWEEP walks the spins and S_DONE waits for the output.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_OWN   = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  function automatic logic signed [EB-1:0] sat_e(input logic signed [63:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[EB-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[EB-1:0];
    end
    return v[EB-1:0];
  endfunction

  state_t state_r, state_nxt;

  // Latched item.
  qmsu_pkg::kind_t kind_r;
  logic [SAW-1:0]          row_r, col_r;
  logic                    row_ok_r, col_ok_r;
  logic [COUPLING_BITS-1:0] coup_in_r;
  logic                    spin_in_r;
  logic signed [EB-1:0]    delta_in_r, energy_in_r;
  logic [31:0]             beta_r;
  logic [15:0]             rand_r;

  logic [6:0]              spin_count_r;
  logic signed [EB-1:0]    energy_r;
  logic [MAX_SPINS-1:0]    vld_r;
  logic                    rvld_r;
  logic                    own_spin_r;
  logic signed [EB-1:0]    own_delta_r;
  logic                    acc_r;
  logic [CNT_W-1:0]        j_r, n_lim;
  logic                    sw_v_r;
  logic [SAW-1:0]          sw_j_r;

  logic                    out_valid_r, out_acc_r, out_spin_r;
  logic signed [31:0]      out_energy_r, out_delta_r;

  // Memory ports.
  logic                    st_we, st_re, cp_we, cp_re;
  logic [SAW-1:0]          st_waddr, st_raddr;
  logic [EB:0]             st_wdata, st_rdata;
  logic [CAW-1:0]          cp_waddr, cp_raddr;
  logic [COUPLING_BITS-1:0] cp_rdata;

  logic                    rd_spin;
  logic signed [EB-1:0]    rd_delta;
  logic signed [63:0]      q2, t64;
  logic                    ev_start, ev_done, ev_take;
  logic                    in_fire, out_free;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign n_lim    = (32'(spin_count_r) > MAX_SPINS) ? CNT_W'(MAX_SPINS)
                                                    : CNT_W'(spin_count_r);

  // Entries never loaded read as zero.
  assign rd_spin  = rvld_r & st_rdata[EB];
  assign rd_delta = rvld_r ? st_rdata[EB-1:0] : '0;

  // Coupling contribution: +2Q when the new spin differs from spin j, else -2Q.
  assign q2  = {{(64-COUPLING_BITS){cp_rdata[COUPLING_BITS-1]}}, cp_rdata} <<< 1;
  assign t64 = (own_spin_r != rd_spin) ? q2 : -q2;

  assign ev_start = (state_r == S_LOOK) && (kind_r == qmsu_pkg::KIND_CONSIDER) && row_ok_r;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = row_r;
    st_wdata = {spin_in_r, delta_in_r};
    st_re    = 1'b0;
    st_raddr = row_r;
    cp_we    = 1'b0;
    cp_waddr = CAW'(32'(row_r) * MAX_SPINS + 32'(col_r));
    cp_re    = 1'b0;
    cp_raddr = CAW'(32'(row_r) * MAX_SPINS + 32'(j_r));
    unique case (state_r)
      S_READ: begin
        st_re = 1'b1;
        st_we = (kind_r == qmsu_pkg::KIND_SPIN) && row_ok_r;
        cp_we = (kind_r == qmsu_pkg::KIND_COUPLING) && row_ok_r && col_ok_r;
      end
      S_OWN: begin
        st_we    = 1'b1;
        st_wdata = {~own_spin_r, sat_e(-64'(own_delta_r))};
      end
      S_SWEEP: begin
        st_re    = (j_r < n_lim);
        cp_re    = st_re;
        st_raddr = j_r[SAW-1:0];
        st_we    = sw_v_r && (sw_j_r != row_r);
        st_waddr = sw_j_r;
        st_wdata = {rd_spin, sat_e(64'(rd_delta) + t64)};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_READ;
      S_READ:  state_nxt = S_LOOK;
      S_LOOK:  state_nxt = ev_start ? S_EVAL : S_DONE;
      S_EVAL:  if (ev_done) state_nxt = ev_take ? S_OWN : S_DONE;
      S_OWN:   state_nxt = S_SWEEP;
      S_SWEEP: if (!(j_r < n_lim) && !sw_v_r) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      spin_count_r <= 7'd64;
      energy_r     <= '0;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      sw_v_r       <= 1'b0;
      acc_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        spin_count_r <= cfg_wdata;
      end
      if (st_we) begin
        vld_r[st_waddr] <= 1'b1;
      end
      if (state_r == S_READ && kind_r == qmsu_pkg::KIND_ENERGY) begin
        energy_r <= energy_in_r;
      end
      if (state_r == S_OWN) begin
        energy_r <= sat_e(64'(energy_r) + 64'(own_delta_r));
      end
      sw_v_r <= (state_r == S_SWEEP) && st_re;
      if (state_r == S_LOOK) begin
        acc_r <= 1'b0;
      end else if (state_r == S_EVAL && ev_done) begin
        acc_r <= ev_take;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= qmsu_pkg::kind_t'(in_kind);
      row_r       <= SAW'(in_row_index);
      col_r       <= SAW'(in_col_index);
      row_ok_r    <= 32'(in_row_index) < MAX_SPINS;
      col_ok_r    <= 32'(in_col_index) < MAX_SPINS;
      coup_in_r   <= COUPLING_BITS'($unsigned(in_coupling_value));
      spin_in_r   <= in_spin_value;
      delta_in_r  <= sat_e(64'(in_delta_value));
      energy_in_r <= sat_e(64'(in_energy_value));
      beta_r      <= in_inverse_temp;
      rand_r      <= in_random_fraction;
    end
    if (st_re) begin
      rvld_r <= vld_r[st_raddr];
    end
    if (state_r == S_LOOK) begin
      own_spin_r  <= (kind_r == qmsu_pkg::KIND_SPIN) ? spin_in_r : rd_spin;
      own_delta_r <= (kind_r == qmsu_pkg::KIND_SPIN) ? delta_in_r : rd_delta;
    end
    if (state_r == S_OWN) begin
      own_spin_r  <= ~own_spin_r;
      own_delta_r <= sat_e(-64'(own_delta_r));
      j_r         <= '0;
    end
    if (state_r == S_SWEEP && st_re) begin
      j_r    <= j_r + CNT_W'(1);
      sw_j_r <= j_r[SAW-1:0];
    end
    if (state_r == S_DONE && out_free) begin
      out_acc_r    <= acc_r;
      out_spin_r   <= row_ok_r & own_spin_r;
      out_energy_r <= 32'(64'(energy_r));
      out_delta_r  <= row_ok_r ? 32'(64'(own_delta_r)) : 32'sd0;
    end
  end

  qmsu_ram #(.WIDTH(EB + 1), .DEPTH(MAX_SPINS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qmsu_ram #(.WIDTH(COUPLING_BITS), .DEPTH(MAX_SPINS * MAX_SPINS)) u_coup_ram (
    .clk   (clk),
    .we    (cp_we),
    .waddr (cp_waddr),
    .wdata (coup_in_r),
    .re    (cp_re),
    .raddr (cp_raddr),
    .rdata (cp_rdata)
  );

  qmsu_accept #(.ENERGY_BITS(EB)) u_accept (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ev_start),
    .delta (rd_delta),
    .beta  (beta_r),
    .u     (rand_r),
    .done  (ev_done),
    .take  (ev_take)
  );

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_spin_now   = out_spin_r;
  assign out_energy_now = out_energy_r;
  assign out_delta_now  = out_delta_r;

`ifndef NO_ASSERTIONS
  // The state is always exactly one of the one-hot codes.
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");

  // An accepted item always starts with the state memory read.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_READ)
    else $error("accepted item did not start a read");

  // The test unit only finishes while the controller waits for it.
  a_eval: assert property (@(posedge clk) disable iff (!rst_n)
    ev_done |-> state_r == S_EVAL)
    else $error("test result arrived outside evaluation");

  // The sweep never overwrites the flipped spin's own entry.
  a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && st_we) |-> st_waddr != row_r)
    else $error("sweep wrote the flipped entry");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import qmsu_pkg::*;

  localparam int NSPIN = 64;
  localparam logic signed [63:0] E_HI = 64'sd2147483647;
  localparam logic signed [63:0] E_LO = -64'sd2147483648;

  // Exponential tables kept locally so the scoreboard does not lean on the
  // design's own constants for its decision.
  localparam int unsigned EXP_I [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                          162, 60, 22, 8, 3, 1};
  localparam int unsigned EXP_F [17] = '{65536, 61565, 57835, 54331, 51039,
                                          47947, 45043, 42313, 39750, 37341,
                                          35079, 32954, 30957, 29081, 27319,
                                          25664, 24109};

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] coup;
    logic               spin;
    logic signed [31:0] delta;
    logic signed [31:0] energy;
    logic [31:0]        beta;
    logic [15:0]        rnd;
  } item_t;

  typedef struct packed {
    logic               acc;
    logic               spin;
    logic signed [31:0] energy;
    logic signed [31:0] delta;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [5:0] in_row_index = '0;
  logic [5:0] in_col_index = '0;
  logic signed [15:0] in_coupling_value = '0;
  logic in_spin_value = 1'b0;
  logic signed [31:0] in_delta_value = '0;
  logic signed [31:0] in_energy_value = '0;
  logic [31:0] in_inverse_temp = '0;
  logic [15:0] in_random_fraction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted;
  logic out_spin_now;
  logic signed [31:0] out_energy_now;
  logic signed [31:0] out_delta_now;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qubo_metropolis_spin_update_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_row_index       (in_row_index),
    .in_col_index       (in_col_index),
    .in_coupling_value  (in_coupling_value),
    .in_spin_value      (in_spin_value),
    .in_delta_value     (in_delta_value),
    .in_energy_value    (in_energy_value),
    .in_inverse_temp    (in_inverse_temp),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_spin_now       (out_spin_now),
    .out_energy_now     (out_energy_now),
    .out_delta_now      (out_delta_now),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Shadow copy of the block's state, updated as each item is accepted.
  logic signed [15:0] coup_mem [NSPIN*NSPIN];
  logic               spin_mem [NSPIN];
  logic signed [63:0] delta_mem [NSPIN];
  logic signed [63:0] energy_reg;
  int unsigned        spin_count_reg;

  res_t expected_results [$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  longint cycle_count = 0;

  function automatic logic signed [63:0] clamp_energy(logic signed [63:0] v);
    if (v > E_HI) return E_HI;
    if (v < E_LO) return E_LO;
    return v;
  endfunction

  // Metropolis acceptance with the table-interpolated exponential.
  function automatic bit flip_taken(logic signed [63:0] d, logic [31:0] beta,
                                    logic [15:0] u);
    longint unsigned p, f, k, r, v, e;
    int unsigned ip;
    if (d <= 0) return 1'b1;
    if (beta == 0) return 1'b1;
    if (d > 64'sh0000_0000_FFFF_FFFF) return 1'b0;
    p = longint'(d) * longint'(beta);
    if (p >= (64'd12 << 16)) return 1'b0;
    ip = int'(p >> 16);
    f = p & 64'hFFFF;
    k = f >> 12;
    r = f & 64'hFFF;
    v = EXP_F[k] - (((EXP_F[k] - EXP_F[k+1]) * r + 2048) >> 12);
    e = (EXP_I[ip] * v + 32768) >> 16;
    return longint'(u) < e;
  endfunction

  // Applies one item to the shadow state and returns the result it causes.
  function automatic res_t step_spin_update(item_t it);
    res_t rs;
    int unsigned n;
    logic signed [63:0] sgn, t;
    rs = '0;
    case (kind_t'(it.kind))
      KIND_COUPLING: begin
        coup_mem[it.row*NSPIN + it.col] = it.coup;
      end
      KIND_SPIN: begin
        spin_mem[it.row] = it.spin;
        delta_mem[it.row] = it.delta;
      end
      KIND_ENERGY: energy_reg = it.energy;
      KIND_CONSIDER: begin
        if (flip_taken(delta_mem[it.row], it.beta, it.rnd)) begin
          n = (spin_count_reg > NSPIN) ? NSPIN : spin_count_reg;
          rs.acc = 1'b1;
          spin_mem[it.row] = ~spin_mem[it.row];
          energy_reg = clamp_energy(energy_reg + delta_mem[it.row]);
          sgn = spin_mem[it.row] ? 64'sd1 : -64'sd1;
          for (int j = 0; j < n; j++) begin
            if (j != it.row) begin
              t = sgn * ((spin_mem[j] ? -64'sd2 : 64'sd2) *
                         64'(coup_mem[it.row*NSPIN + j]));
              delta_mem[j] = clamp_energy(delta_mem[j] + t);
            end
          end
          delta_mem[it.row] = clamp_energy(-delta_mem[it.row]);
        end
      end
    endcase
    rs.spin = spin_mem[it.row];
    rs.energy = energy_reg[31:0];
    rs.delta = delta_mem[it.row][31:0];
    return rs;
  endfunction

  // Hands one item to the block; the expectation is queued at acceptance.
  // Called at a falling edge; valid stays up after acceptance until the next
  // item or an idle cycle replaces it.
  task automatic push_item(item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_kind            <= it.kind;
    in_row_index       <= it.row;
    in_col_index       <= it.col;
    in_coupling_value  <= it.coup;
    in_spin_value      <= it.spin;
    in_delta_value     <= it.delta;
    in_energy_value    <= it.energy;
    in_inverse_temp    <= it.beta;
    in_random_fraction <= it.rnd;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(step_spin_update(it));
    @(negedge clk);
  endtask

  // Same as push_item, but also compares the predictor against a hand value.
  task automatic push_checked(item_t it, res_t hand);
    res_t pr;
    push_item(it);
    pr = expected_results[$];
    if (pr !== hand) begin
      $error("directed row: predictor %h, hand value %h", pr, hand);
      fail_count++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    // An accepted flip sweeps the spin memory, so leave room for it.
    repeat (100) @(negedge clk);
  endtask

  task automatic write_spin_count(logic [6:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    spin_count_reg = v;
  endtask

  // Receiver: stalls at random and checks each result against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    res_t ex;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        ex = expected_results.pop_front();
        if (out_accepted !== ex.acc) begin
          $error("accepted: expected %0d, actual %0d", ex.acc, out_accepted);
          fail_count++;
        end
        if (out_spin_now !== ex.spin) begin
          $error("spin_now: expected %0d, actual %0d", ex.spin, out_spin_now);
          fail_count++;
        end
        if (out_energy_now !== ex.energy) begin
          $error("energy_now: expected %0d, actual %0d", ex.energy, out_energy_now);
          fail_count++;
        end
        if (out_delta_now !== ex.delta) begin
          $error("delta_now: expected %0d, actual %0d", ex.delta, out_delta_now);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk)
    out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

  // Watchdog: the slowest correct run is far below this figure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic item_t mk(logic [1:0] k, logic [5:0] r, logic [5:0] c,
                               logic signed [15:0] q, logic s,
                               logic signed [31:0] d, logic signed [31:0] e,
                               logic [31:0] b, logic [15:0] u);
    item_t it;
    it = '{k, r, c, q, s, d, e, b, u};
    return it;
  endfunction

  // Random item over rows below rows_ready. Loads and considers dominate to
  // keep the spin system moving; the caller steers considers onto rows whose
  // coupling row is fully written.
  function automatic item_t rand_item(int unsigned rows_ready);
    item_t it;
    int sel;
    it.kind   = 2'($urandom_range(3));
    it.row    = 6'($urandom_range(rows_ready - 1));
    it.col    = 6'($urandom_range(63));
    it.coup   = 16'($urandom);
    it.spin   = 1'($urandom);
    it.delta  = 32'($urandom);
    it.energy = 32'($urandom);
    it.beta   = 32'($urandom);
    it.rnd    = 16'($urandom);
    sel = $urandom_range(9);
    if (sel < 6) begin
      it.kind = KIND_CONSIDER;
      // Small deltas and betas land inside the exponential's useful range.
      case ($urandom_range(3))
        0: it.beta = 32'($urandom_range(65536));
        1: it.beta = 32'($urandom_range(4096));
        2: it.beta = 0;
        default: ;
      endcase
    end else if (sel < 8) begin
      it.kind = KIND_SPIN;
      if ($urandom_range(1)) it.delta = 32'(int'($urandom_range(400)) - 100);
    end
    return it;
  endfunction

  // Directed table: expected values typed in only where trivially known.
  localparam int NDIR = 14;
  item_t dir_items [NDIR];
  res_t  dir_hand  [NDIR];
  bit    dir_has_hand [NDIR];

  initial begin
    item_t it;
    int phase_pct [4][2];
    int sel;
    phase_pct = '{'{0, 0}, '{46, 0}, '{0, 46}, '{24, 24}};
    for (int i = 0; i < NSPIN*NSPIN; i++) begin
      coup_mem[i] = '0;
    end
    for (int i = 0; i < NSPIN; i++) begin
      spin_mem[i] = 1'b0;
      delta_mem[i] = '0;
    end
    energy_reg = '0;
    spin_count_reg = 64;

    dir_items[0]  = mk(KIND_ENERGY, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0);
    dir_hand[0]   = '{1'b0, 1'b0, 32'sh7FFF_FFFF, 32'sd0};
    dir_items[1]  = mk(KIND_SPIN, 63, 0, 0, 1, 32'sh8000_0000, 0, 0, 0);
    dir_hand[1]   = '{1'b0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000};
    dir_items[2]  = mk(KIND_COUPLING, 63, 63, 16'sh7FFF, 0, 0, 0, 0, 0);
    dir_items[3]  = mk(KIND_COUPLING, 0, 63, 16'sh8000, 0, 0, 0, 0, 0);
    dir_items[4]  = mk(KIND_COUPLING, 63, 0, -16'sd1, 0, 0, 0, 0, 0);
    dir_items[5]  = mk(KIND_ENERGY, 0, 0, 0, 0, 0, 32'sh8000_0000, 0, 0);
    dir_hand[5]   = '{1'b0, 1'b0, 32'sh8000_0000, 32'sd0};
    // Most negative delta flips unconditionally and saturates on negation.
    dir_items[6]  = mk(KIND_CONSIDER, 63, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF);
    dir_items[7]  = mk(KIND_SPIN, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0);
    // Huge product always rejects.
    dir_items[8]  = mk(KIND_CONSIDER, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'h0000);
    dir_hand[8]   = '{1'b0, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF};
    // Zero beta always accepts a positive delta.
    dir_items[9]  = mk(KIND_CONSIDER, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF);
    dir_items[10] = mk(KIND_SPIN, 0, 0, 0, 1, 32'sd1, 0, 0, 0);
    // Product just under the rejection limit, then one that falls exactly on a table entry.
    dir_items[11] = mk(KIND_CONSIDER, 0, 0, 0, 0, 0, 0, 32'h000B_FFFF, 16'h0000);
    dir_items[12] = mk(KIND_CONSIDER, 0, 0, 0, 0, 0, 0, 32'h0000_8000, 16'h9000);
    dir_items[13] = mk(KIND_CONSIDER, 0, 0, 0, 0, 0, 0, 32'h0000_0000, 16'h0000);
    dir_has_hand = '{1, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the coupling rows of spins 0, 1, 2 and 63 completely; only these
    // spins are ever considered, so no sweep reads an unwritten entry.
    for (int r = 0; r < NSPIN; r++)
      if (r < 3 || r == NSPIN - 1)
        for (int c = 0; c < NSPIN; c++)
          push_item(mk(KIND_COUPLING, 6'(r), 6'(c), 16'($urandom), 0, 0, 0, 0, 0));
    wait_idle();

    for (int i = 0; i < NDIR; i++) begin
      if (dir_has_hand[i]) push_checked(dir_items[i], dir_hand[i]);
      else push_item(dir_items[i]);
    end
    wait_idle();

    // Random phases, each with an idle pattern (the four patterns recur from phase 4 on) and a spin count setting.
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = phase_pct[ph % 4][0];
      recv_stall_pct = phase_pct[ph % 4][1];
      case (ph)
        0: write_spin_count(7'd2);
        1: write_spin_count(7'd64);
        2: write_spin_count(7'd127);
        3: write_spin_count(7'd0);
        4: write_spin_count(7'd1);
        default: write_spin_count(7'($urandom_range(2, 64)));
      endcase
      for (int n = 0; n < 66; n++) begin
        it = rand_item(64);
        if (ph >= 6 && $urandom_range(1)) begin
          // Crowding items onto rows 0 to 7 keeps them correlated.
          it.row = 6'($urandom_range(7));
        end
        if (it.kind == KIND_CONSIDER) begin
          sel = int'($urandom_range(3));
          it.row = (sel == 3) ? 6'd63 : 6'(sel);
        end
        push_item(it);
      end
      wait_idle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
